[hw/rtl/dcsp_pkg.sv]
// ----------------------------------------------------------------------------
// dcsp_pkg: shared types and constants for the dual channel sample pairer
// Entry layout, status codes and the decoder result bundle.
// ----------------------------------------------------------------------------
package dcsp_pkg;

  localparam int unsigned SampleW  = 20;
  localparam int unsigned CountW   = 32;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned OutDataW = 112;  // 107 payload bits padded to 14 bytes

  localparam logic [1:0] TagValid = 2'd1;
  localparam logic [1:0] SlotIr   = 2'd0;
  localparam logic [1:0] SlotRed  = 2'd1;

  typedef enum logic [StatusW-1:0] {
    STATUS_PAIR_OUT    = 3'd0,
    STATUS_IR_HELD     = 3'd1,
    STATUS_IR_REPLACED = 3'd2,
    STATUS_RED_UNPAIRED = 3'd3,
    STATUS_BAD_ENTRY   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PHASE_FIRST  = 2'd0,
    PHASE_SECOND = 2'd1,
    PHASE_THIRD  = 2'd2
  } phase_e;

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_e;

  // Outcome of one completed entry
  typedef struct packed {
    status_e            status;
    logic [SampleW-1:0] sample;
    logic               pair_inc;
    logic               bad_inc;
    logic               held_load;  // load sample into the held IR register
    logic               held_next;  // IR-held flag after this entry
  } entry_res_t;

endpackage

[hw/rtl/dcsp_entry_decode.sv]
// ----------------------------------------------------------------------------
// dcsp_entry_decode: classify one completed three-byte entry
// Splits slot, tag and sample and decides status, counter and hold updates.
// ----------------------------------------------------------------------------
module dcsp_entry_decode (
  input  logic [dcsp_pkg::ByteW-1:0] first_byte_i,
  input  logic [dcsp_pkg::ByteW-1:0] second_byte_i,
  input  logic [dcsp_pkg::ByteW-1:0] third_byte_i,
  input  logic                       ir_held_i,
  output dcsp_pkg::entry_res_t       res_o
);
  import dcsp_pkg::*;

  logic [1:0] slot;
  logic [1:0] tag;

  assign slot = first_byte_i[7:6];
  assign tag  = first_byte_i[5:4];

  always_comb begin
    res_o           = '0;
    res_o.sample    = {first_byte_i[3:0], second_byte_i, third_byte_i};
    res_o.held_next = ir_held_i;
    if (tag != TagValid || (slot != SlotIr && slot != SlotRed)) begin
      // drop any held IR sample
      res_o.status    = STATUS_BAD_ENTRY;
      res_o.bad_inc   = 1'b1;
      res_o.held_next = 1'b0;
    end else if (slot == SlotIr) begin
      res_o.status    = ir_held_i ? STATUS_IR_REPLACED : STATUS_IR_HELD;
      res_o.bad_inc   = ir_held_i;
      res_o.held_load = 1'b1;
      res_o.held_next = 1'b1;
    end else if (ir_held_i) begin
      res_o.status    = STATUS_PAIR_OUT;
      res_o.pair_inc  = 1'b1;
      res_o.held_next = 1'b0;
    end else begin
      res_o.status    = STATUS_RED_UNPAIRED;
      res_o.bad_inc   = 1'b1;
    end
  end

endmodule

[hw/rtl/dual_channel_sample_pairer_top.sv]
// ----------------------------------------------------------------------------
// dual_channel_sample_pairer_top: pair IR and red samples from a FIFO stream
// Byte stream in, one status item out per completed three-byte entry.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one item per byte. tdata carries the raw FIFO byte, most
//   significant byte of an entry first; tuser carries the opcode (0 = data
//   byte, 1 = clear the held IR sample and realign to the first byte).
//   Master channel: one item per third byte of an entry, carrying status,
//   red and IR samples (nonzero only for a pair) and both running counters.
//   Path: a third byte goes through the input register, then the result
//   register, before it appears on the master side.
//   Throughput: one byte per cycle sustained; the pipeline advances whenever
//   the result register is empty or being taken, so a waiting result lets
//   at most one more byte into the input register before the input stalls.
//   Stall: while the receiver holds tready low with a result pending, the
//   result holds, the input register holds its byte and tready on the slave
//   side drops once that register is full.
//   Reset: byte phase, held IR flag, both counters and all valids clear.
// ----------------------------------------------------------------------------
module dual_channel_sample_pairer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dcsp_pkg::ByteW-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tuser,   // [0] opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] entry_status, [22:3] red_sample, [42:23] ir_sample,
  // [74:43] pairs_total, [106:75] bad_total, [111:107] zero
  output logic [dcsp_pkg::OutDataW-1:0] m_axis_tdata
);
  import dcsp_pkg::*;

  // Input register
  logic              in_valid_q;
  logic              in_op_q;
  logic [ByteW-1:0]  in_byte_q;

  // Entry state
  phase_e             phase_q, phase_d;
  logic [ByteW-1:0]   first_q, first_d;
  logic [ByteW-1:0]   second_q, second_d;
  logic               held_q, held_d;
  logic [SampleW-1:0] held_val_q, held_val_d;
  logic [CountW-1:0]  pairs_q, pairs_d;
  logic [CountW-1:0]  bad_q, bad_d;

  // Result register
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [SampleW-1:0] out_red_q, out_red_d;
  logic [SampleW-1:0] out_ir_q, out_ir_d;

  logic       advance;
  logic       work;
  entry_res_t res;

  // The pipeline moves when the result slot is free or being emptied
  assign advance       = !out_valid_q || m_axis_tready;
  assign work          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  dcsp_entry_decode u_decode (
    .first_byte_i  (first_q),
    .second_byte_i (second_q),
    .third_byte_i  (in_byte_q),
    .ir_held_i     (held_q),
    .res_o         (res)
  );

  always_comb begin
    phase_d      = phase_q;
    first_d      = first_q;
    second_d     = second_q;
    held_d       = held_q;
    held_val_d   = held_val_q;
    pairs_d      = pairs_q;
    bad_d        = bad_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_red_d    = out_red_q;
    out_ir_d     = out_ir_q;
    if (work) begin
      if (in_op_q == OP_CLEAR) begin
        // drop held sample, realign phase
        held_d  = 1'b0;
        phase_d = PHASE_FIRST;
      end else begin
        unique case (phase_q)
          PHASE_SECOND: begin
            second_d = in_byte_q;
            phase_d  = PHASE_THIRD;
          end
          PHASE_THIRD: begin
            phase_d      = PHASE_FIRST;
            held_d       = res.held_next;
            pairs_d      = pairs_q + CountW'(res.pair_inc);
            bad_d        = bad_q + CountW'(res.bad_inc);
            out_valid_d  = 1'b1;
            out_status_d = res.status;
            out_red_d    = res.pair_inc ? res.sample : '0;
            out_ir_d     = res.pair_inc ? held_val_q : '0;
            if (res.held_load) begin
              held_val_d = res.sample;
            end
          end
          default: begin
            first_d = in_byte_q;
            phase_d = PHASE_SECOND;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PHASE_FIRST;
      first_q     <= '0;
      second_q    <= '0;
      held_q      <= 1'b0;
      held_val_q  <= '0;
      pairs_q     <= '0;
      bad_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      phase_q     <= phase_d;
      first_q     <= first_d;
      second_q    <= second_d;
      held_q      <= held_d;
      held_val_q  <= held_val_d;
      pairs_q     <= pairs_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
    out_status_q <= out_status_d;
    out_red_q    <= out_red_d;
    out_ir_q     <= out_ir_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, bad_q, pairs_q, out_ir_q, out_red_q, out_status_q};

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for dual_channel_sample_pairer_top
// Drives raw FIFO bytes and clear items into the slave stream, predicts each
// entry status, sample pair and running counters in a local model of the
// pairer, and checks every master-side result against that prediction while
// both sides stall at random and the receiver once holds off for a long time.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dcsp_pkg::*;

  // Run limits, counted in clock cycles
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;      // input reg plus result reg, with margin
  localparam int unsigned HoldCycles  = 300;    // long receiver hold-off

  // One predicted result item, fields in master tdata order
  typedef struct {
    status_e            status;
    logic [SampleW-1:0] red;
    logic [SampleW-1:0] ir;
    logic [CountW-1:0]  pairs;
    logic [CountW-1:0]  bad;
  } pair_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ByteW-1:0]      s_axis_tdata = '0;   // [7:0] data_byte
  logic                  s_axis_tuser = 1'b0; // [0] opcode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [2:0] entry_status, [22:3] red_sample, [42:23] ir_sample,
  // [74:43] pairs_total, [106:75] bad_total, [111:107] zero
  logic [OutDataW-1:0]   m_axis_tdata;

  // Local copy of the pairer state
  phase_e             byte_phase_m = PHASE_FIRST;
  logic [ByteW-1:0]   first_byte_m = '0;
  logic [ByteW-1:0]   second_byte_m = '0;
  logic               ir_held_m = 1'b0;
  logic [SampleW-1:0] held_ir_m = '0;
  logic [CountW-1:0]  pair_count_m = '0;
  logic [CountW-1:0]  bad_count_m = '0;

  pair_result_t expected_results[$];

  bit          quiet = 1'b0;       // no idling on either side while set
  int unsigned hold_until = 0;     // receiver holds tready low until this cycle
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned bytes_accepted = 0;
  int unsigned clears_accepted = 0;
  int unsigned results_checked = 0;

  dual_channel_sample_pairer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Count cycles and abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Advance the pairer model by one accepted item; queue a result on the
  // third byte of an entry.
  task automatic pairer_model_step(input opcode_e op, input logic [ByteW-1:0] b);
    logic [1:0]         slot;
    logic [1:0]         tag;
    logic [SampleW-1:0] sample;
    pair_result_t       res;
    if (op == OP_CLEAR) begin
      // Drop the held IR sample and realign; counters and bytes stay
      ir_held_m    = 1'b0;
      byte_phase_m = PHASE_FIRST;
      return;
    end
    case (byte_phase_m)
      PHASE_SECOND: begin
        second_byte_m = b;
        byte_phase_m  = PHASE_THIRD;
      end
      PHASE_THIRD: begin
        byte_phase_m = PHASE_FIRST;
        slot   = first_byte_m[7:6];
        tag    = first_byte_m[5:4];
        sample = {first_byte_m[3:0], second_byte_m, b};
        res.red = '0;
        res.ir  = '0;
        if (tag != TagValid || slot > SlotRed) begin
          // Bad tag or slot: count it and lose any held IR
          ir_held_m   = 1'b0;
          bad_count_m = bad_count_m + 1;
          res.status  = STATUS_BAD_ENTRY;
        end else if (slot == SlotIr) begin
          // IR over IR counts as bad but the new sample still takes the slot
          if (ir_held_m) begin
            bad_count_m = bad_count_m + 1;
            res.status  = STATUS_IR_REPLACED;
          end else begin
            res.status  = STATUS_IR_HELD;
          end
          held_ir_m = sample;
          ir_held_m = 1'b1;
        end else if (ir_held_m) begin
          res.red      = sample;
          res.ir       = held_ir_m;
          pair_count_m = pair_count_m + 1;
          ir_held_m    = 1'b0;
          res.status   = STATUS_PAIR_OUT;
        end else begin
          // Red with no IR partner waiting
          bad_count_m = bad_count_m + 1;
          res.status  = STATUS_RED_UNPAIRED;
        end
        res.pairs = pair_count_m;
        res.bad   = bad_count_m;
        expected_results.push_back(res);
      end
      default: begin
        first_byte_m = b;
        byte_phase_m = PHASE_SECOND;
      end
    endcase
  endtask

  // Feed the model from the slave handshake
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      bytes_accepted <= bytes_accepted + 1;
      if (s_axis_tuser == OP_CLEAR) clears_accepted <= clears_accepted + 1;
      pairer_model_step(opcode_e'(s_axis_tuser), s_axis_tdata);
    end
  end

  // Compare one master item with the oldest prediction
  task automatic check_result(input logic [OutDataW-1:0] data);
    pair_result_t exp_res;
    logic [2:0]         got_status;
    logic [SampleW-1:0] got_red;
    logic [SampleW-1:0] got_ir;
    logic [CountW-1:0]  got_pairs;
    logic [CountW-1:0]  got_bad;
    logic [4:0]         got_pad;
    got_status = data[2:0];
    got_red    = data[22:3];
    got_ir     = data[42:23];
    got_pairs  = data[74:43];
    got_bad    = data[106:75];
    got_pad    = data[111:107];
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: status %0d", got_status);
      error_count++;
      return;
    end
    exp_res = expected_results.pop_front();
    results_checked++;
    if (got_status != exp_res.status) begin
      $error("entry_status: expected %0d, actual %0d", exp_res.status, got_status);
      error_count++;
    end
    if (got_red != exp_res.red) begin
      $error("red_sample: expected %0d, actual %0d", $signed(exp_res.red), $signed(got_red));
      error_count++;
    end
    if (got_ir != exp_res.ir) begin
      $error("ir_sample: expected %0d, actual %0d", $signed(exp_res.ir), $signed(got_ir));
      error_count++;
    end
    if (got_pairs != exp_res.pairs) begin
      $error("pairs_total: expected %0d, actual %0d", exp_res.pairs, got_pairs);
      error_count++;
    end
    if (got_bad != exp_res.bad) begin
      $error("bad_total: expected %0d, actual %0d", exp_res.bad, got_bad);
      error_count++;
    end
    if (got_pad != '0) begin
      $error("tdata padding: expected 0, actual %0d", got_pad);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
  end

  // Receiver: hold off during the pressure window, else stall at random unless quiet
  always @(negedge clk_i) begin
    if (cycle_count < hold_until) begin
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(99) < 16) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one item and wait for its handshake; at random, idle first unless
  // quiet is set. Keep tvalid high between back-to-back items.
  task automatic send_item(input opcode_e op, input logic [ByteW-1:0] b);
    int unsigned gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(99) < 9) begin
      gap = $urandom_range(3, 1);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Send a 24-bit entry word, most significant byte first
  task automatic send_entry(input logic [23:0] word);
    send_item(OP_DATA, word[23:16]);
    send_item(OP_DATA, word[15:8]);
    send_item(OP_DATA, word[7:0]);
  endtask

  // Mostly well-formed IR/red entries with random samples, some random
  // (often bad) headers and the odd clear dropped in anywhere.
  task automatic send_random_bytes(input int unsigned n_items);
    int unsigned sent;
    int unsigned kind;
    logic [23:0] word;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      word = 24'($urandom);
      if (kind < 40) begin
        word[23:20] = {SlotIr, TagValid};
      end else if (kind < 80) begin
        word[23:20] = {SlotRed, TagValid};
      end
      for (int i = 2; i >= 0; i--) begin
        if ($urandom_range(99) < 4) begin
          send_item(OP_CLEAR, 8'($urandom));
          sent++;
        end
        send_item(OP_DATA, word[i*8 +: 8]);
        sent++;
      end
    end
  endtask

  // Stop offering, wait for every predicted result, then let the pipeline
  // settle
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Every status, sample extremes, a mid-entry clear that drops a held IR
  task automatic test_directed_entries();
    send_entry({SlotIr, TagValid, 20'h7FFFF});   // IR held, largest positive
    send_entry({SlotRed, TagValid, 20'h80000});  // pair, most negative red
    send_entry({SlotIr, TagValid, 20'h00000});   // IR held
    send_entry({SlotIr, TagValid, 20'hFFFFF});   // IR over IR, new value -1
    send_item(OP_DATA, 8'hA5);                   // partial entry...
    send_item(OP_CLEAR, 8'hFF);                  // ...realigned, held IR dropped
    send_entry({SlotRed, TagValid, 20'h12345});  // red without IR
    send_entry({SlotIr, TagValid, 20'h54321});
    send_entry({2'd3, 2'd3, 20'hFFFFF});         // bad slot and tag, drops IR
    send_entry({SlotRed, TagValid, 20'h00001});  // red without IR again
    wait_drained();
  endtask

  // Random stream with idling on both sides
  task automatic test_random_stream();
    send_random_bytes(550);
    wait_drained();
  endtask

  // Random stream with no idling at all on either side
  task automatic test_back_to_back();
    quiet = 1'b1;
    send_random_bytes(180);
    wait_drained();
    quiet = 1'b0;
  endtask

  // Hold the receiver off while the sender keeps offering, so the block
  // fills up and drops its input tready
  task automatic test_output_stall();
    quiet = 1'b1;
    hold_until = cycle_count + HoldCycles;
    send_random_bytes(120);
    wait_drained();
    quiet = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_entries();
    test_random_stream();
    test_back_to_back();
    test_output_stall();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    $display("Checked %0d entry results from %0d accepted bytes (%0d clears).",
             results_checked, bytes_accepted, clears_accepted);
    $display("Final counters: %0d pairs, %0d bad; random stalls plus one long hold-off.",
             pair_count_m, bad_count_m);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
